### design/piano_and_melody_sequencer_macros.svh
// Assertion macros used by the checker of the sequencer.
`ifndef PIANO_AND_MELODY_SEQUENCER_MACROS_SVH
`define PIANO_AND_MELODY_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pams_pkg.sv
package pams_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_KEY        = 3'd1,
    OP_SWITCH_ONE = 3'd2,
    OP_SWITCH_TWO = 3'd3,
    OP_LOAD       = 3'd4
  } opcode_t;

  typedef enum logic {
    CFG_TICKS_PER_UNIT = 1'b0,
    CFG_GAP_UNITS      = 1'b1
  } cfg_index_t;

  localparam logic [23:0] TICKS_RESET = 24'd100;
  localparam logic [7:0]  GAP_RESET   = 8'd15;
  localparam logic [4:0]  TONE_MAX    = 5'd20;
  localparam logic [1:0]  OCTAVE_LAST = 2'd2;

  typedef struct packed {
    opcode_t     opcode;
    logic        key_valid;
    logic [1:0]  key_number;
    logic [1:0]  load_song;
    logic [5:0]  load_position;
    logic        load_pause;
    logic [4:0]  load_tone;
    logic [7:0]  load_delay;
  } request_t;

  typedef struct packed {
    logic        tone_on;
    logic [4:0]  tone_sel;
    logic        mode_now;
    logic [1:0]  octave_now;
    logic [1:0]  song_now;
    logic        octave_blink;
  } result_t;

  typedef struct packed {
    logic        pause;
    logic [4:0]  tone;
    logic [7:0]  delay;
  } entry_t;

  function automatic logic [5:0] octave_offset(input logic [1:0] octave);
    return 6'({octave, 3'b000}) - 6'(octave);
  endfunction

  function automatic logic [4:0] key_tone(input logic [1:0] key, input logic [1:0] octave);
    logic [5:0] sum;
    sum = 6'(key) + octave_offset(octave);
    return sum[4:0];
  endfunction

  // The stored tone is folded into one octave, shifted and clamped at the top.
  function automatic logic [4:0] entry_tone(input logic [4:0] tone,
                                            input logic [1:0] octave);
    logic [4:0] r;
    logic [5:0] sum;
    r = tone;
    if (r >= 5'd28) begin
      r = r - 5'd28;
    end else if (r >= 5'd21) begin
      r = r - 5'd21;
    end else if (r >= 5'd14) begin
      r = r - 5'd14;
    end else if (r >= 5'd7) begin
      r = r - 5'd7;
    end
    sum = 6'(r) + octave_offset(octave);
    if (sum > 6'(TONE_MAX)) begin
      sum = 6'(TONE_MAX);
    end
    return sum[4:0];
  endfunction

endpackage

### design/pams_song_ram.sv
module pams_song_ram
  import pams_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/piano_and_melody_sequencer.sv
// Tone controller with a piano mode and an autoplay mode.
// Requests arrive on in_valid/in_ready with a request_t payload: ticks, key
// changes, the two switches and song memory loads. Every request yields exactly
// one result_t on out_valid/out_ready, showing the tone and status after it.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce;
// it takes effect at the next unit or gap start. One request is accepted every
// cycle unless the receiver stalls: a request that starts a song entry reads the
// song memory, whose registered data feeds the update of the following request.
// An output register and one result stage separate the two sides, so a request
// is still taken while a result waits; when the receiver stalls with both held,
// in_ready drops until the output register is taken.
// Reset clears the mode, octave, song position and counters and restores the
// register defaults of 100 ticks per unit and 15 gap units. Song memory
// contents are undefined until loaded and need no clearing pass.
module piano_and_melody_sequencer
  import pams_pkg::*;
#(
  parameter int SONGS          = 4,
  parameter int NOTES_PER_SONG = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  request_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_data,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DEPTH = SONGS * NOTES_PER_SONG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AXW   = AW + 1;
  localparam int SW    = (SONGS > 1) ? $clog2(SONGS) : 1;
  localparam int EW    = $clog2(NOTES_PER_SONG + 1);

  logic [23:0]   ticks_per_unit;
  logic [7:0]    gap_units;

  logic          play_mode, mode_next;
  logic [1:0]    octave_reg, octave_next;
  logic [SW-1:0] song_index, song_next;
  logic [EW-1:0] entry_index, entry_next;
  logic          in_gap, gap_next;
  logic [7:0]    unit_countdown, unit_next;
  logic [23:0]   tick_countdown, tick_next;
  logic          sounding, sounding_next;
  logic [4:0]    sounding_tone, tone_next;

  logic          pend;
  logic          rd_zero;
  logic          s1_valid, s1_blink;
  logic          s1_adv, accept;

  logic          start_entry, period_done, blink, load_en, past_end;

  entry_t        rd_data, word;
  logic          eff_gap, eff_sounding;
  logic [7:0]    eff_unit;
  logic [4:0]    eff_tone;
  logic          cur_gap, cur_sounding;
  logic [7:0]    cur_unit;
  logic [4:0]    cur_tone;

  logic [AXW-1:0] rd_full, wr_full;
  entry_t         wr_data;
  result_t        result;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // The entry read by the previous request is applied here before any use.
  always_comb begin
    word         = rd_zero ? '0 : rd_data;
    eff_gap      = (word.delay == 8'd0);
    eff_unit     = eff_gap ? gap_units : word.delay;
    eff_sounding = !eff_gap && !word.pause;
    eff_tone     = eff_sounding ? entry_tone(word.tone, octave_reg) : 5'd0;
    cur_gap      = pend ? eff_gap : in_gap;
    cur_unit     = pend ? eff_unit : unit_countdown;
    cur_sounding = pend ? eff_sounding : sounding;
    cur_tone     = pend ? eff_tone : sounding_tone;
  end

  always_comb begin
    mode_next     = play_mode;
    octave_next   = octave_reg;
    song_next     = song_index;
    entry_next    = entry_index;
    gap_next      = cur_gap;
    unit_next     = cur_unit;
    tick_next     = tick_countdown;
    sounding_next = cur_sounding;
    tone_next     = cur_tone;
    start_entry   = 1'b0;
    period_done   = 1'b0;
    blink         = 1'b0;
    load_en       = 1'b0;
    if (accept) begin
      case (in_data.opcode)
        OP_TICK: begin
          if (play_mode) begin
            if (cur_unit == 8'd0) begin
              period_done = 1'b1;
            end else if (tick_countdown > 24'd1) begin
              tick_next = tick_countdown - 24'd1;
            end else begin
              unit_next = cur_unit - 8'd1;
              tick_next = ticks_per_unit;
              if (cur_unit == 8'd1) begin
                period_done = 1'b1;
              end
            end
          end
        end
        OP_KEY: begin
          if (!play_mode) begin
            sounding_next = in_data.key_valid;
            tone_next     = in_data.key_valid ?
                            key_tone(in_data.key_number, octave_reg) : 5'd0;
          end
        end
        OP_SWITCH_ONE: begin
          sounding_next = 1'b0;
          tone_next     = 5'd0;
          mode_next     = !play_mode;
          gap_next      = 1'b0;
          unit_next     = 8'd0;
          tick_next     = 24'd0;
          entry_next    = '0;
          if (!play_mode) begin
            song_next   = '0;
            start_entry = 1'b1;
          end
        end
        OP_SWITCH_TWO: begin
          if (!play_mode) begin
            octave_next = (octave_reg == OCTAVE_LAST) ? 2'd0 : octave_reg + 2'd1;
            blink       = 1'b1;
            if (cur_sounding) begin
              sounding_next = in_data.key_valid;
              tone_next     = in_data.key_valid ?
                              key_tone(in_data.key_number, octave_next) : 5'd0;
            end
          end else begin
            song_next   = (32'(song_index) == SONGS - 1) ? '0 : song_index + 1'b1;
            entry_next  = '0;
            start_entry = 1'b1;
          end
        end
        OP_LOAD: begin
          load_en = (32'(in_data.load_song) < SONGS) &&
                    (32'(in_data.load_position) < NOTES_PER_SONG);
        end
        default: begin
        end
      endcase
    end
    if (period_done) begin
      entry_next  = cur_gap ? '0 : EW'(entry_index + 1'b1);
      start_entry = 1'b1;
    end
    if (start_entry) begin
      tick_next = ticks_per_unit;
    end
  end

  assign past_end = (32'(entry_next) >= NOTES_PER_SONG);
  assign rd_full  = AXW'(song_next) * AXW'(NOTES_PER_SONG) + AXW'(entry_next);
  assign wr_full  = AXW'(in_data.load_song) * AXW'(NOTES_PER_SONG) +
                    AXW'(in_data.load_position);
  assign wr_data  = '{pause: in_data.load_pause, tone: in_data.load_tone,
                      delay: in_data.load_delay};

  pams_song_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_song_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_full[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (start_entry),
    .rd_addr (rd_full[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TICKS_RESET;
      gap_units      <= GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TICKS_PER_UNIT: ticks_per_unit <= cfg_data;
        CFG_GAP_UNITS:      gap_units      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode      <= 1'b0;
      octave_reg     <= 2'd0;
      song_index     <= '0;
      entry_index    <= '0;
      in_gap         <= 1'b0;
      unit_countdown <= 8'd0;
      tick_countdown <= 24'd0;
      sounding       <= 1'b0;
      sounding_tone  <= 5'd0;
      pend           <= 1'b0;
      rd_zero        <= 1'b0;
    end else begin
      play_mode      <= mode_next;
      octave_reg     <= octave_next;
      song_index     <= song_next;
      entry_index    <= entry_next;
      in_gap         <= gap_next;
      unit_countdown <= unit_next;
      tick_countdown <= tick_next;
      sounding       <= sounding_next;
      sounding_tone  <= tone_next;
      pend           <= start_entry;
      rd_zero        <= past_end;
    end
  end

  always_comb begin
    result.tone_on      = cur_sounding;
    result.tone_sel     = cur_sounding ? cur_tone : 5'd0;
    result.mode_now     = play_mode;
    result.octave_now   = octave_reg;
    result.song_now     = 2'(song_index);
    result.octave_blink = s1_blink;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_blink <= blink;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

endmodule

### design/pams_checker.sv
`include "piano_and_melody_sequencer_macros.svh"

module pams_checker
  import pams_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  `PAMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `PAMS_ASSERT_SAME(a_silent_index, out_valid, out_data.tone_on || out_data.tone_sel == 5'd0, "silent result carries a tone")
  `PAMS_ASSERT_SAME(a_status_range, out_valid, out_data.tone_sel <= TONE_MAX && out_data.octave_now != 2'd3 && !(out_data.octave_blink && out_data.mode_now), "result status out of range")
  `PAMS_ASSERT_NEXT(a_backpressure, in_valid && in_ready && out_valid && !out_ready, !in_ready || out_ready, "request taken with both stages full")

endmodule

bind piano_and_melody_sequencer pams_checker u_pams_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
